// File: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the parameter frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  localparam int unsigned IdxW = 17;

  localparam logic [7:0] HDR_BYTE0   = 8'hAA;
  localparam logic [7:0] HDR_BYTE1   = 8'h75;
  localparam logic [7:0] CMD_PARAM   = 8'hD0;
  localparam logic [7:0] REPLY_SYNC0 = 8'h55;
  localparam logic [7:0] REPLY_SYNC1 = 8'h7A;
  localparam logic [7:0] REPLY_ERR_LO = 8'hFA;
  localparam logic [7:0] REPLY_ERR_HI = 8'hFB;
  localparam logic [7:0] REPLY_PAD   = 8'h00;
  localparam logic [7:0] CMD_HIGH    = 8'h80;

  // byte offsets inside the frame
  localparam logic [IdxW-1:0] OFS_HDR0   = 17'd0;
  localparam logic [IdxW-1:0] OFS_HDR1   = 17'd1;
  localparam logic [IdxW-1:0] OFS_CMD    = 17'd2;
  localparam logic [IdxW-1:0] OFS_LEN_HI = 17'd3;
  localparam logic [IdxW-1:0] OFS_LEN_LO = 17'd4;
  localparam logic [IdxW-1:0] OFS_RSVD   = 17'd5;
  localparam logic [IdxW-1:0] OFS_FLAG   = 17'd6;
  localparam logic [IdxW-1:0] IDX_MAX    = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NOT_PARAM = 3'd2,
    ST_LEN_ERR   = 3'd3,
    ST_SUM_ERR   = 3'd4
  } status_e;

  // reply word positions: status item then five reply bytes
  typedef enum logic [2:0] {
    W_STATUS = 3'd0,
    W_SYNC0  = 3'd1,
    W_SYNC1  = 3'd2,
    W_CODE   = 3'd3,
    W_PAD    = 3'd4,
    W_SUM    = 3'd5
  } word_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic        rw_flag;
    logic [15:0] payload_len;
    logic        err_reply;
  } summary_t;

endpackage

`default_nettype wire

// File: rtl/pfc_in_if.sv
// ----------------------------------------------------------------------------
// pfc_in_if
// Received byte channel: valid/ready handshake with byte and end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// File: rtl/pfc_out_if.sv
// ----------------------------------------------------------------------------
// pfc_out_if
// Result channel: status items and error reply bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [7:0]  command;
  logic        rw_flag;
  logic [15:0] payload_len;
  logic [7:0]  reply_byte;
  logic        final_res;

  modport source (output valid, output kind, output status, output command,
                  output rw_flag, output payload_len, output reply_byte,
                  output final_res, input ready);
  modport sink   (input valid, input kind, input status, input command,
                  input rw_flag, input payload_len, input reply_byte,
                  input final_res, output ready);
endinterface

`default_nettype wire

// File: rtl/pfc_frame_track.sv
// ----------------------------------------------------------------------------
// pfc_frame_track
// Per-frame state: byte offset, running xor, captured fields, status decode.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_frame_track (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              acc_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              last_i,
  output logic                   done_o,
  output pfc_pkg::summary_t      summary_o
);

  logic [pfc_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]               xor_q, xor_d;
  logic                     hdr_q, hdr_d;
  logic [7:0]               cmd_q, cmd_d;
  logic [15:0]              len_q, len_d;
  logic [7:0]               flag_q, flag_d;
  logic                     sum_q, sum_d;
  logic [pfc_pkg::IdxW-1:0] sum_pos;

  always_comb begin
    hdr_d  = hdr_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    flag_d = flag_q;
    sum_d  = sum_q;
    if (idx_q == pfc_pkg::OFS_HDR0) begin
      hdr_d = (rx_byte_i == pfc_pkg::HDR_BYTE0);
    end else if (idx_q == pfc_pkg::OFS_HDR1) begin
      hdr_d = hdr_q && (rx_byte_i == pfc_pkg::HDR_BYTE1);
    end else if (idx_q == pfc_pkg::OFS_CMD) begin
      cmd_d = rx_byte_i;
    end else if (idx_q == pfc_pkg::OFS_LEN_HI) begin
      len_d = {rx_byte_i, len_q[7:0]};
    end else if (idx_q == pfc_pkg::OFS_LEN_LO) begin
      len_d = {len_q[15:8], rx_byte_i};
    end else if (idx_q == pfc_pkg::OFS_FLAG) begin
      flag_d = rx_byte_i;
    end
    // checksum sits right after the data
    sum_pos = {1'b0, len_d} + pfc_pkg::OFS_FLAG;
    if (idx_q >= pfc_pkg::OFS_RSVD && idx_q == sum_pos) begin
      sum_d = (rx_byte_i == xor_q);
    end
    xor_d = xor_q ^ rx_byte_i;
    idx_d = (idx_q != pfc_pkg::IDX_MAX) ? idx_q + 17'd1 : idx_q;
  end

  always_comb begin
    summary_o.command     = cmd_d;
    summary_o.rw_flag     = flag_d[0];
    summary_o.payload_len = len_d;
    // total bytes below seven means the last offset is below six
    if (idx_q < pfc_pkg::OFS_FLAG || !hdr_d) begin
      summary_o.status = pfc_pkg::ST_SHORT;
    end else if (cmd_d != pfc_pkg::CMD_PARAM || flag_d > 8'd1) begin
      summary_o.status = pfc_pkg::ST_NOT_PARAM;
    end else if (sum_pos > idx_q) begin
      summary_o.status = pfc_pkg::ST_LEN_ERR;
    end else if (!sum_d) begin
      summary_o.status = pfc_pkg::ST_SUM_ERR;
    end else begin
      summary_o.status = pfc_pkg::ST_OK;
    end
    summary_o.err_reply = (summary_o.status == pfc_pkg::ST_LEN_ERR) ||
                          (summary_o.status == pfc_pkg::ST_SUM_ERR);
  end

  assign done_o = acc_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      xor_q  <= '0;
      hdr_q  <= 1'b1;
      cmd_q  <= '0;
      len_q  <= '0;
      flag_q <= '0;
      sum_q  <= 1'b0;
    end else if (acc_i) begin
      if (last_i) begin
        idx_q  <= '0;
        xor_q  <= '0;
        hdr_q  <= 1'b1;
        cmd_q  <= '0;
        len_q  <= '0;
        flag_q <= '0;
        sum_q  <= 1'b0;
      end else begin
        idx_q  <= idx_d;
        xor_q  <= xor_d;
        hdr_q  <= hdr_d;
        cmd_q  <= cmd_d;
        len_q  <= len_d;
        flag_q <= flag_d;
        sum_q  <= sum_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pfc_reply_seq.sv
// ----------------------------------------------------------------------------
// pfc_reply_seq
// Result register and word sequencer for the status item and error reply.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_reply_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  pfc_pkg::summary_t      summary_i,
  output logic                   free_o,
  pfc_out_if.source              res_o
);

  logic              valid_q, valid_d;
  pfc_pkg::word_e    word_q, word_d;
  pfc_pkg::summary_t sum_q;
  logic              pop;
  logic              last_word;
  logic [7:0]        code_byte;

  assign code_byte = (sum_q.command < pfc_pkg::CMD_HIGH) ? pfc_pkg::REPLY_ERR_LO
                                                         : pfc_pkg::REPLY_ERR_HI;

  assign last_word = (word_q == pfc_pkg::W_SUM) ||
                     (word_q == pfc_pkg::W_STATUS && !sum_q.err_reply);
  assign pop       = valid_q && res_o.ready;
  assign free_o    = !valid_q || (res_o.ready && last_word);

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (pop) begin
      if (last_word) begin
        valid_d = 1'b0;
      end else begin
        word_d = pfc_pkg::word_e'(word_q + 3'd1);
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
      word_d  = pfc_pkg::W_STATUS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= pfc_pkg::W_STATUS;
    end else begin
      valid_q <= valid_d;
      word_q  <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= summary_i;
    end
  end

  always_comb begin
    unique case (word_q)
      pfc_pkg::W_SYNC0: res_o.reply_byte = pfc_pkg::REPLY_SYNC0;
      pfc_pkg::W_SYNC1: res_o.reply_byte = pfc_pkg::REPLY_SYNC1;
      pfc_pkg::W_CODE:  res_o.reply_byte = code_byte;
      pfc_pkg::W_PAD:   res_o.reply_byte = pfc_pkg::REPLY_PAD;
      pfc_pkg::W_SUM:   res_o.reply_byte = pfc_pkg::REPLY_SYNC0 ^ pfc_pkg::REPLY_SYNC1 ^
                                           code_byte ^ pfc_pkg::REPLY_PAD;
      default:          res_o.reply_byte = 8'h00;
    endcase
  end

  assign res_o.valid       = valid_q;
  assign res_o.kind        = (word_q != pfc_pkg::W_STATUS);
  assign res_o.status      = sum_q.status;
  assign res_o.command     = sum_q.command;
  assign res_o.rw_flag     = sum_q.rw_flag;
  assign res_o.payload_len = sum_q.payload_len;
  assign res_o.final_res   = last_word;

  // new frame result only lands when the slot frees
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded while previous result pending");

  // reply bytes only follow a length or checksum error
  a_reply_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && word_q != pfc_pkg::W_STATUS) |->
      (sum_q.status == pfc_pkg::ST_LEN_ERR || sum_q.status == pfc_pkg::ST_SUM_ERR))
    else $error("reply byte without error status");

  // a taken word that is not final leaves the next word in place
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_word) |=> (valid_q && word_q == pfc_pkg::word_e'($past(word_q) + 3'd1)))
    else $error("reply sequence broken");

endmodule

`default_nettype wire

// File: rtl/param_frame_checker.sv
// ----------------------------------------------------------------------------
// param_frame_checker
// Checks a serial parameter frame byte by byte and reports status and error
// replies.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  rx_i    | in  | one frame byte with end_of_buffer marker
//  res_o   | out | status item, then five reply bytes on length/checksum error
//
//  one byte taken per ready cycle; frame state updates in the accepting cycle
//  the last byte of a frame loads the result register, which drives res_o
//  one or six result words per frame, one word per cycle while res_o.ready
//  rx_i.ready drops only while a frame result is still being sent
//  reset (asynchronous, active low) starts a new frame with no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module param_frame_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfc_in_if.sink     rx_i,
  pfc_out_if.source  res_o
);

  logic              accept;
  logic              done;
  logic              free;
  pfc_pkg::summary_t summary;

  assign rx_i.ready = free;
  assign accept     = rx_i.valid && rx_i.ready;

  pfc_frame_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (accept),
    .rx_byte_i (rx_i.rx_byte),
    .last_i    (rx_i.end_of_buffer),
    .done_o    (done),
    .summary_o (summary)
  );

  pfc_reply_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (done),
    .summary_i (summary),
    .free_o    (free),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
